@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable; prop may use |-> or |=>.
`define AST_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// Implication checked in the same cycle.
`define AST_IMPL(lbl, clk, rstn, ante, cons, msg) \
  `AST_PROP(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

@@ sv/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int BLOCKS_DEFAULT = 256;

  localparam int CMD_W        = 1;
  localparam int INDEX_W      = 8;
  localparam int COUNT_W      = 9;
  localparam int BYTES_W      = 13;
  localparam int STRIDE_W     = 14;
  localparam int OFFSET_W     = 21;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 13;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_POOL_COUNT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

  localparam logic [COUNT_W-1:0]  POOL_COUNT_RST  = 9'd256;
  localparam logic [BYTES_W-1:0]  BLOCK_BYTES_RST = 13'd4;
  localparam logic [STRIDE_W-1:0] HEADER_BYTES    = 14'd4;

endpackage

@@ sv/fbpa_ram.sv @@
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/fixed_block_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size block pool allocator with a LIFO free list and bump index.
// ----------------------------------------------------------------------------
// Each accepted item returns exactly one result item. Allocates served by the
// bump index, failed allocates and frees load the result register straight from
// the idle state; an allocate that pops the free list passes through the pop
// state, because the next link is read from the link RAM (registered read data)
// before the head is updated. One item is in work at a time; a new item is
// taken only when the result register is empty or its item leaves in the same
// cycle, so a stalled result blocks the input. The link RAM is never read before
// it is written, so it needs no clearing after reset. Configuration writes are
// taken in any cycle out of reset and belong between items.
module fixed_block_pool_allocator_core #(
  parameter int BLOCKS = fbpa_pkg::BLOCKS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fbpa_pkg::CMD_W-1:0]       in_command,
  input  logic [fbpa_pkg::INDEX_W-1:0]     in_block_index,
  input  logic                             in_null_handle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_granted,
  output logic [fbpa_pkg::INDEX_W-1:0]     out_granted_index,
  output logic [fbpa_pkg::OFFSET_W-1:0]    out_byte_offset,
  output logic [fbpa_pkg::COUNT_W-1:0]     out_in_use_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import fbpa_pkg::*;

  localparam int IW = $clog2(BLOCKS);
  localparam int EW = (IW > INDEX_W) ? IW : INDEX_W;
  localparam logic [16:0] BLOCKS_W = 17'(BLOCKS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic                 state_r, state_nxt;
  logic [COUNT_W-1:0]   pool_count_r;
  logic [BYTES_W-1:0]   block_bytes_r;
  logic [IW-1:0]        free_head_r, free_head_nxt;
  logic                 free_empty_r, free_empty_nxt;
  logic [COUNT_W-1:0]   bump_r, bump_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [INDEX_W-1:0]   pop_idx_r, pop_idx_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_granted_r;
  logic [INDEX_W-1:0]   out_index_r;
  logic [OFFSET_W-1:0]  out_offset_r;
  logic [COUNT_W-1:0]   out_count_r;

  logic                 accept;
  logic [COUNT_W-1:0]   limit;
  logic [EW-1:0]        head_e;
  logic [IW-1:0]        free_blk;
  logic [IW-1:0]        mod_tbl [256];

  logic                 ram_we;
  logic [IW:0]          ram_wdata;
  logic [IW:0]          ram_rdata;

  logic                 res_load;
  logic                 res_granted;
  logic [INDEX_W-1:0]   res_index;
  logic [STRIDE_W-1:0]  stride;
  logic [21:0]          prod;
  logic [OFFSET_W-1:0]  res_offset;

  for (genvar gi = 0; gi < 256; gi++) begin : g_mod
    assign mod_tbl[gi] = IW'(gi % BLOCKS);
  end

  assign free_blk  = mod_tbl[in_block_index];
  assign head_e    = EW'(free_head_r);
  assign limit     = ({8'd0, pool_count_r} < BLOCKS_W) ? pool_count_r : BLOCKS_W[COUNT_W-1:0];
  assign in_ready  = rst_n && (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = rst_n;
  assign ram_wdata = {free_empty_r, free_head_r};

  fbpa_ram #(
    .WIDTH (IW + 1),
    .DEPTH (BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_blk),
    .wdata (ram_wdata),
    .raddr (free_head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    free_empty_nxt = free_empty_r;
    bump_nxt       = bump_r;
    count_nxt      = count_r;
    pop_idx_nxt    = pop_idx_r;
    ram_we         = 1'b0;
    res_load       = 1'b0;
    res_granted    = 1'b0;
    res_index      = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_ALLOC) begin
            if ((count_r < limit) && !free_empty_r) begin
              state_nxt   = ST_POP;
              pop_idx_nxt = head_e[INDEX_W-1:0];
            end else if ((count_r < limit) && (bump_r < limit)) begin
              bump_nxt    = bump_r + 9'd1;
              count_nxt   = count_r + 9'd1;
              res_load    = 1'b1;
              res_granted = 1'b1;
              res_index   = bump_r[INDEX_W-1:0];
            end else begin
              res_load = 1'b1;
            end
          end else if (!in_null_handle) begin
            ram_we         = 1'b1;
            free_head_nxt  = free_blk;
            free_empty_nxt = 1'b0;
            count_nxt      = (count_r != '0) ? count_r - 9'd1 : count_r;
            res_load       = 1'b1;
          end else begin
            res_load = 1'b1;
          end
        end
      end
      ST_POP: begin
        free_head_nxt  = ram_rdata[IW-1:0];
        free_empty_nxt = ram_rdata[IW];
        count_nxt      = count_r + 9'd1;
        res_load       = 1'b1;
        res_granted    = 1'b1;
        res_index      = pop_idx_r;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign stride     = {1'b0, block_bytes_r} + HEADER_BYTES;
  assign prod       = 22'(res_index) * 22'(stride);
  assign res_offset = res_granted ? (prod[OFFSET_W-1:0] + OFFSET_W'(HEADER_BYTES)) : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pool_count_r  <= POOL_COUNT_RST;
      block_bytes_r <= BLOCK_BYTES_RST;
      free_head_r   <= '0;
      free_empty_r  <= 1'b1;
      bump_r        <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      free_empty_r <= free_empty_nxt;
      bump_r       <= bump_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_POOL_COUNT:  pool_count_r  <= cfg_data[COUNT_W-1:0];
          CFG_BLOCK_BYTES: block_bytes_r <= cfg_data[BYTES_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pop_idx_r <= pop_idx_nxt;
    if (res_load) begin
      out_granted_r <= res_granted;
      out_index_r   <= res_index;
      out_offset_r  <= res_offset;
      out_count_r   <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_granted_index = out_index_r;
  assign out_byte_offset   = out_offset_r;
  assign out_in_use_count  = out_count_r;

endmodule

@@ sv/fbpa_checker.sv @@
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks for the block pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbpa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_granted,
  input logic [fbpa_pkg::INDEX_W-1:0]  out_granted_index,
  input logic [fbpa_pkg::OFFSET_W-1:0] out_byte_offset,
  input logic [fbpa_pkg::COUNT_W-1:0]  out_in_use_count
);

  import fbpa_pkg::*;

  localparam int RES_W = 1 + INDEX_W + OFFSET_W + COUNT_W;

  logic             stalled;
  logic             grant_seen;
  logic             nogrant_seen;
  logic [RES_W-1:0] res_bits;
  logic             zero_fields;
  logic             count_ok;

  assign stalled      = out_valid && !out_ready;
  assign grant_seen   = out_valid && out_granted;
  assign nogrant_seen = out_valid && !out_granted;
  assign res_bits     = {out_granted, out_granted_index, out_byte_offset, out_in_use_count};
  assign zero_fields  = (out_granted_index == '0) && (out_byte_offset == '0);
  assign count_ok     = (out_in_use_count != '0) && (out_in_use_count <= POOL_COUNT_RST);

  `AST_PROP(a_out_hold, clk, rst_n, stalled |=> out_valid && $stable(res_bits), "result not held")

  `AST_IMPL(a_nogrant_zero, clk, rst_n, nogrant_seen, zero_fields, "ungranted item has data")

  `AST_IMPL(a_grant_offset, clk, rst_n, grant_seen, out_byte_offset != '0, "zero grant offset")

  `AST_IMPL(a_grant_count, clk, rst_n, grant_seen, count_ok, "bad in-use count on grant")

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (.*);
